// ===== sv/sgwl_pkg.sv =====
// Shared types and constants for the start-gap wear leveler.
// No dependencies; used by sgwl_div, start_gap_wear_leveler and tb_top.
package sgwl_pkg;

	localparam int MAX_GROUPS_DEF      = 64;
	localparam int MAX_GROUP_LINES_DEF = 256;
	localparam int WEAR_BITS_DEF       = 32;

	// serial divider width: covers base+1, group ids and offset plus stale start
	localparam int DIV_W     = 18;
	localparam int CFG_IDX_W = 3;

	localparam logic [14:0] RST_NODE_COUNT  = 15'd16383;
	localparam logic [6:0]  RST_GROUP_COUNT = 7'd64;
	localparam logic [13:0] RST_SPLIT_POINT = 14'd16127;
	localparam logic [31:0] RST_GAP_PERIOD  = 32'd100;
	localparam logic [31:0] RST_WEAR_LIMIT  = 32'd1000000;
	localparam logic [6:0]  RST_UNIT_COUNT  = 7'd1;
	localparam logic [5:0]  RST_UNIT_INDEX  = 6'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NODE_COUNT,
		REG_GROUP_COUNT,
		REG_SPLIT_POINT,
		REG_GAP_PERIOD,
		REG_WEAR_LIMIT,
		REG_UNIT_COUNT,
		REG_UNIT_INDEX
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CB,
		S_CP,
		S_CS,
		S_D1,
		S_D2,
		S_GRD,
		S_D3,
		S_WRD,
		S_WMOD,
		S_D4,
		S_GWR,
		S_OUT
	} state_t;

	typedef struct packed {
		logic             go;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

endpackage

// ===== sv/sgwl_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on sgwl_pkg for its request and response structs.
module sgwl_div (
	input  logic                clk,
	input  logic                arst_n,
	input  sgwl_pkg::div_req_t  req,
	output sgwl_pkg::div_rsp_t  rsp
);

	localparam int DW  = sgwl_pkg::DIV_W;
	localparam int CNW = $clog2(DW + 1);

	logic [DW-1:0]  rem_q, quo_q, dsr_q;
	logic [CNW-1:0] cnt_q;
	logic           run_q, done_q;
	logic [DW:0]    sh, diff;

	always_comb begin
		sh   = {rem_q, quo_q[DW-1]};
		diff = sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= CNW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (run_q) begin
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
			end else begin
				rem_q <= sh[DW-1:0];
			end
			quo_q <= {quo_q[DW-2:0], ~diff[DW]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== sv/start_gap_wear_leveler.sv =====
// Start-gap wear leveler: one write per item, wear and group state in two RAMs.
// One item at a time; the next is accepted in the done cycle.
// Reset: clearing pass over all MAX_GROUPS*(MAX_GROUP_LINES+1) wear entries, then the
// divides of S_CB, S_CP and S_CS derive group sizes, also after every config write;
// busy covers both. Uses sgwl_pkg, sgwl_div.
module start_gap_wear_leveler #(
	parameter int MAX_GROUPS      = sgwl_pkg::MAX_GROUPS_DEF,
	parameter int MAX_GROUP_LINES = sgwl_pkg::MAX_GROUP_LINES_DEF,
	parameter int WEAR_BITS       = sgwl_pkg::WEAR_BITS_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           start,
	output logic                                           busy,
	input  logic [13:0]                                    logical_line,
	input  logic                                           cfg_valid,
	output logic                                           cfg_ready,
	input  logic [sgwl_pkg::CFG_IDX_W-1:0]                 cfg_index,
	input  logic [31:0]                                    cfg_data,
	output logic                                           done,
	output logic                                           owned,
	output logic [((MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1)-1:0] local_group,
	output logic [$clog2(MAX_GROUP_LINES + 1)-1:0]         physical_slot,
	output logic [WEAR_BITS-1:0]                           slot_wear,
	output logic                                           slot_failed,
	output logic                                           gap_moved,
	output logic [31:0]                                    failure_total
);

	localparam int LG_W   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int SLOT_W = $clog2(MAX_GROUP_LINES + 1);
	localparam int SLOTS  = MAX_GROUP_LINES + 1;
	localparam int WDEPTH = MAX_GROUPS * SLOTS;
	localparam int WA_W   = $clog2(WDEPTH);
	localparam int GW     = 2 * SLOT_W + 32;
	localparam int CMP_W  = (WEAR_BITS > 32) ? WEAR_BITS : 32;
	localparam int DW     = sgwl_pkg::DIV_W;

	sgwl_pkg::state_t   state_q, state_d;
	logic               first_q;
	sgwl_pkg::div_req_t dreq;
	sgwl_pkg::div_rsp_t drsp;

	logic [14:0] nc_q;
	logic [6:0]  gc_q, uc_q;
	logic [13:0] sp_q;
	logic [31:0] gp_q, wl_q;
	logic [5:0]  ui_q;
	logic        dirty_q, deg_q;
	logic [DW-1:0] base_q, nbig_q, pu_q, spd_q;

	logic [13:0]       line_q;
	logic [DW-1:0]     gid_q, off_q, size_q;
	logic [LG_W-1:0]   lg_q;
	logic [SLOT_W-1:0] slot_q, st_q, gs_q;
	logic [31:0]       ph_q;
	logic [WA_W-1:0]   wa_q, clr_q;
	logic [WEAR_BITS-1:0] wear_q;
	logic              own_q, failed_q, moved_q;
	logic [31:0]       fcnt_q;

	logic [WEAR_BITS-1:0] wmem [WDEPTH];
	logic [GW-1:0]        gmem [MAX_GROUPS];
	logic [WEAR_BITS-1:0] wm_rd_q, wm_wdata;
	logic [GW-1:0]        gm_rd_q, gm_wdata;
	logic                 wm_we, wm_re, gm_we, gm_re;
	logic [WA_W-1:0]      wm_addr;
	logic [LG_W-1:0]      gm_addr;

	logic              hi, cfg_we, own_ok;
	logic [DW-1:0]     size_c, gap_c, m_c;
	logic [SLOT_W-1:0] rd_st, rd_gs, slot_c;
	logic [31:0]       rd_ph;
	logic [WEAR_BITS-1:0] winc;
	logic              wfail, pmove, wrap;
	logic [32:0]       ph1;
	logic [SLOT_W:0]   gs1;

	sgwl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	assign {rd_st, rd_gs, rd_ph} = gm_rd_q;

	always_comb begin
		hi     = line_q > sp_q;
		size_c = (gid_q < nbig_q) ? base_q + 1'b1 : base_q;
		own_ok = (drsp.quot == DW'(ui_q)) && (32'(size_c) <= 32'(MAX_GROUP_LINES));
		gap_c  = (DW'(rd_gs) < size_q) ? size_q - DW'(rd_gs) : '0;
		m_c    = drsp.rem;
		slot_c = (m_c >= gap_c) ? SLOT_W'(m_c + 1'b1) : SLOT_W'(m_c);
		winc   = (wm_rd_q != '1) ? wm_rd_q + 1'b1 : wm_rd_q;
		wfail  = CMP_W'(winc) >= CMP_W'(wl_q);
		ph1    = {1'b0, rd_ph} + 33'd1;
		pmove  = ph1 >= {1'b0, gp_q};
		gs1    = {1'b0, rd_gs} + 1'b1;
		wrap   = pmove && (DW'(gs1) >= size_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sgwl_pkg::S_CLEAR: if (clr_q == WA_W'(WDEPTH - 1)) state_d = sgwl_pkg::S_IDLE;
			sgwl_pkg::S_IDLE: begin
				if (dirty_q) begin
					state_d = sgwl_pkg::S_CB;
				end else if (start) begin
					state_d = deg_q ? sgwl_pkg::S_OUT : sgwl_pkg::S_D1;
				end
			end
			sgwl_pkg::S_CB:   if (drsp.done) state_d = sgwl_pkg::S_CP;
			sgwl_pkg::S_CP:   if (drsp.done) state_d = sgwl_pkg::S_CS;
			sgwl_pkg::S_CS:   if (drsp.done) state_d = sgwl_pkg::S_IDLE;
			sgwl_pkg::S_D1:   if (drsp.done) state_d = sgwl_pkg::S_D2;
			sgwl_pkg::S_D2: begin
				if (drsp.done) state_d = own_ok ? sgwl_pkg::S_GRD : sgwl_pkg::S_OUT;
			end
			sgwl_pkg::S_GRD:  state_d = sgwl_pkg::S_D3;
			sgwl_pkg::S_D3:   if (drsp.done) state_d = sgwl_pkg::S_WRD;
			sgwl_pkg::S_WRD:  state_d = sgwl_pkg::S_WMOD;
			sgwl_pkg::S_WMOD: state_d = wrap ? sgwl_pkg::S_D4 : sgwl_pkg::S_GWR;
			sgwl_pkg::S_D4:   if (drsp.done) state_d = sgwl_pkg::S_GWR;
			sgwl_pkg::S_GWR:  state_d = sgwl_pkg::S_OUT;
			sgwl_pkg::S_OUT:  state_d = sgwl_pkg::S_IDLE;
			default:          state_d = sgwl_pkg::S_CLEAR;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy          = (state_q != sgwl_pkg::S_IDLE) || dirty_q;
		dreq.go       = 1'b0;
		dreq.dividend = '0;
		dreq.divisor  = '0;
		wm_we    = 1'b0;
		wm_re    = 1'b0;
		wm_addr  = wa_q;
		wm_wdata = '0;
		gm_we    = 1'b0;
		gm_re    = 1'b0;
		gm_addr  = lg_q;
		gm_wdata = {st_q, gs_q, ph_q};
		case (state_q)
			sgwl_pkg::S_CLEAR: begin
				wm_we   = 1'b1;
				wm_addr = clr_q;
				gm_we   = 32'(clr_q) < MAX_GROUPS;
				gm_addr = LG_W'(clr_q);
				gm_wdata = '0;
			end
			sgwl_pkg::S_CB: begin
				dreq.go       = first_q;
				dreq.dividend = DW'(nc_q);
				dreq.divisor  = DW'(gc_q);
			end
			sgwl_pkg::S_CP: begin
				dreq.go       = first_q;
				dreq.dividend = DW'(gc_q);
				dreq.divisor  = DW'(uc_q);
			end
			sgwl_pkg::S_CS: begin
				dreq.go       = first_q;
				dreq.dividend = DW'(sp_q);
				dreq.divisor  = base_q + 1'b1;
			end
			sgwl_pkg::S_D1: begin
				dreq.go       = first_q;
				dreq.dividend = hi ? DW'(line_q - sp_q - 1'b1) : DW'(line_q);
				dreq.divisor  = hi ? base_q : base_q + 1'b1;
			end
			sgwl_pkg::S_D2: begin
				dreq.go       = first_q;
				dreq.dividend = gid_q;
				dreq.divisor  = pu_q;
			end
			sgwl_pkg::S_GRD: gm_re = 1'b1;
			sgwl_pkg::S_D3: begin
				dreq.go       = first_q;
				dreq.dividend = off_q + DW'(rd_st);
				dreq.divisor  = size_q;
			end
			sgwl_pkg::S_WRD: wm_re = 1'b1;
			sgwl_pkg::S_WMOD: begin
				wm_we    = 1'b1;
				wm_wdata = wfail ? '0 : winc;
			end
			sgwl_pkg::S_D4: begin
				dreq.go       = first_q;
				dreq.dividend = DW'(rd_st) + 1'b1;
				dreq.divisor  = size_q;
			end
			sgwl_pkg::S_GWR: gm_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wm_we) wmem[wm_addr] <= wm_wdata;
		if (wm_re) wm_rd_q <= wmem[wm_addr];
	end

	always_ff @(posedge clk) begin
		if (gm_we) gmem[gm_addr] <= gm_wdata;
		if (gm_re) gm_rd_q <= gmem[gm_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgwl_pkg::S_CLEAR;
			first_q <= 1'b0;
			clr_q   <= '0;
			dirty_q <= 1'b1;
			deg_q   <= 1'b1;
			fcnt_q  <= '0;
			done    <= 1'b0;
			nc_q    <= sgwl_pkg::RST_NODE_COUNT;
			gc_q    <= sgwl_pkg::RST_GROUP_COUNT;
			sp_q    <= sgwl_pkg::RST_SPLIT_POINT;
			gp_q    <= sgwl_pkg::RST_GAP_PERIOD;
			wl_q    <= sgwl_pkg::RST_WEAR_LIMIT;
			uc_q    <= sgwl_pkg::RST_UNIT_COUNT;
			ui_q    <= sgwl_pkg::RST_UNIT_INDEX;
		end else begin
			state_q <= state_d;
			first_q <= state_d != state_q;
			done    <= state_q == sgwl_pkg::S_OUT;
			if (state_q == sgwl_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_we) begin
				dirty_q <= 1'b1;
				case (sgwl_pkg::cfg_reg_t'(cfg_index))
					sgwl_pkg::REG_NODE_COUNT:  nc_q <= cfg_data[14:0];
					sgwl_pkg::REG_GROUP_COUNT: gc_q <= cfg_data[6:0];
					sgwl_pkg::REG_SPLIT_POINT: sp_q <= cfg_data[13:0];
					sgwl_pkg::REG_GAP_PERIOD:  gp_q <= cfg_data;
					sgwl_pkg::REG_WEAR_LIMIT:  wl_q <= cfg_data;
					sgwl_pkg::REG_UNIT_COUNT:  uc_q <= cfg_data[6:0];
					sgwl_pkg::REG_UNIT_INDEX:  ui_q <= cfg_data[5:0];
					default: ;
				endcase
			end else if (state_q == sgwl_pkg::S_IDLE && dirty_q) begin
				dirty_q <= 1'b0;
			end
			if (state_q == sgwl_pkg::S_CS && drsp.done) begin
				deg_q <= (gc_q == '0) || (uc_q == '0) || (base_q == '0) || (pu_q == '0)
					|| (32'(pu_q) > MAX_GROUPS);
			end
			if (state_q == sgwl_pkg::S_WMOD && wfail && fcnt_q != '1) fcnt_q <= fcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sgwl_pkg::S_IDLE: begin
				line_q  <= logical_line;
				own_q   <= 1'b0;
				failed_q <= 1'b0;
				moved_q <= 1'b0;
			end
			sgwl_pkg::S_CB: if (drsp.done) begin
				base_q <= drsp.quot;
				nbig_q <= drsp.rem;
			end
			sgwl_pkg::S_CP: if (drsp.done) pu_q  <= drsp.quot;
			sgwl_pkg::S_CS: if (drsp.done) spd_q <= drsp.quot;
			sgwl_pkg::S_D1: if (drsp.done) begin
				gid_q <= hi ? drsp.quot + spd_q + 1'b1 : drsp.quot;
				off_q <= drsp.rem;
			end
			sgwl_pkg::S_D2: if (drsp.done) begin
				lg_q   <= LG_W'(drsp.rem);
				size_q <= size_c;
				own_q  <= own_ok;
			end
			sgwl_pkg::S_D3: if (drsp.done) begin
				slot_q <= slot_c;
				wa_q   <= WA_W'(WA_W'(lg_q) * WA_W'(SLOTS)) + WA_W'(slot_c);
			end
			sgwl_pkg::S_WMOD: begin
				wear_q   <= wfail ? '0 : winc;
				failed_q <= wfail;
				moved_q  <= pmove;
				st_q     <= rd_st;
				ph_q     <= pmove ? 32'd0 : ph1[31:0];
				if (!pmove) begin
					gs_q <= rd_gs;
				end else if (wrap) begin
					gs_q <= '0;
				end else begin
					gs_q <= gs1[SLOT_W-1:0];
				end
			end
			sgwl_pkg::S_D4: if (drsp.done) st_q <= SLOT_W'(drsp.rem);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == sgwl_pkg::S_OUT) begin
			owned         <= own_q;
			local_group   <= own_q ? lg_q : '0;
			physical_slot <= own_q ? slot_q : '0;
			slot_wear     <= own_q ? wear_q : '0;
			slot_failed   <= own_q && failed_q;
			gap_moved     <= own_q && moved_q;
			failure_total <= fcnt_q;
		end
	end

endmodule

// ===== sv/sgwl_checker.sv =====
// Port-level checks for start_gap_wear_leveler, attached by bind.
// Depends only on the top level's ports and parameters.
module sgwl_checker #(
	parameter int LG_W      = 6,
	parameter int SLOT_W    = 9,
	parameter int WEAR_BITS = 32
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic                 owned,
	input logic [LG_W-1:0]      local_group,
	input logic [SLOT_W-1:0]    physical_slot,
	input logic [WEAR_BITS-1:0] slot_wear,
	input logic                 slot_failed,
	input logic                 gap_moved
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_unowned_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !owned |-> slot_wear == '0 && !slot_failed && !gap_moved
			&& local_group == '0 && physical_slot == '0)
		else $error("unowned result carries nonzero fields");

	a_fail_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done && slot_failed |-> slot_wear == '0 && owned)
		else $error("failed slot wear not cleared");

endmodule

bind start_gap_wear_leveler sgwl_checker #(
	.LG_W      (LG_W),
	.SLOT_W    (SLOT_W),
	.WEAR_BITS (WEAR_BITS)
) u_sgwl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.owned         (owned),
	.local_group   (local_group),
	.physical_slot (physical_slot),
	.slot_wear     (slot_wear),
	.slot_failed   (slot_failed),
	.gap_moved     (gap_moved)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for start_gap_wear_leveler: directed and random line writes
// across several register settings, checked against an in-bench start-gap predictor.
// Depends on sgwl_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;

	localparam int NGROUPS   = 64;
	localparam int NSLOTS    = 257;
	localparam logic [sgwl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam longint unsigned SAT = 64'hFFFF_FFFF;

	typedef struct {
		logic        owned;
		logic [5:0]  lgroup;
		logic [8:0]  slot;
		logic [31:0] wear;
		logic        failed;
		logic        moved;
		logic [31:0] total;
	} wear_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [13:0] logical_line = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [sgwl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic done, owned, slot_failed, gap_moved;
	logic [5:0] local_group;
	logic [8:0] physical_slot;
	logic [31:0] slot_wear, failure_total;

	start_gap_wear_leveler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.logical_line(logical_line), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .owned(owned),
		.local_group(local_group), .physical_slot(physical_slot), .slot_wear(slot_wear),
		.slot_failed(slot_failed), .gap_moved(gap_moved), .failure_total(failure_total)
	);

	// predictor state
	longint unsigned node_cnt, grp_cnt, split_pt, period, limit, units, unit_no;
	longint unsigned wear_mem [NGROUPS*NSLOTS];
	longint unsigned start_ofs [NGROUPS];
	longint unsigned gap_cnt [NGROUPS];
	longint unsigned phase_cnt [NGROUPS];
	longint unsigned fail_cnt;

	logic [13:0] corner_lines [10] = '{14'd0, 14'd16383, 14'd16127, 14'd16128, 14'd16382,
		14'd255, 14'd256, 14'd8191, 14'h2AAA, 14'h1555};
	logic [13:0] line_q [$];
	wear_result_t expected_q [$];
	int errors = 0;
	int n_results = 0, n_owned = 0, n_failed = 0, n_moved = 0;
	bit no_idle = 0;
	int hold = 0;
	logic nxt_start;

	initial forever #4 clk = ~clk;

	function automatic wear_result_t map_write(input logic [13:0] ln);
		wear_result_t r;
		longint unsigned line, base, per_unit, gid, off, lg, size, gap, slot, w, ph;
		line = ln;
		r = '{default: '0};
		r.total = fail_cnt[31:0];
		if (grp_cnt == 0 || units == 0) return r;
		base = node_cnt / grp_cnt;
		per_unit = grp_cnt / units;
		if (base == 0 || per_unit == 0 || per_unit > NGROUPS) return r;
		if (line > split_pt) begin
			gid = 1 + split_pt / (base + 1) + (line - split_pt - 1) / base;
			off = (line - split_pt - 1) % base;
		end else begin
			gid = line / (base + 1);
			off = line % (base + 1);
		end
		if (gid / per_unit != unit_no) return r;
		lg = gid % per_unit;
		size = (gid < node_cnt % grp_cnt) ? base + 1 : base;
		if (size > NSLOTS - 1) return r;
		gap = (gap_cnt[lg] < size) ? size - gap_cnt[lg] : 0;
		slot = (off + start_ofs[lg]) % size;
		if (slot >= gap) slot++;
		w = wear_mem[lg*NSLOTS + slot];
		if (w < SAT) w++;
		if (w >= limit) begin
			r.failed = 1'b1;
			w = 0;
			if (fail_cnt < SAT) fail_cnt++;
		end
		wear_mem[lg*NSLOTS + slot] = w;
		ph = phase_cnt[lg] + 1;
		if (ph >= period) begin
			ph = 0;
			r.moved = 1'b1;
			gap_cnt[lg]++;
			if (gap_cnt[lg] >= size) begin
				gap_cnt[lg] = 0;
				start_ofs[lg] = (start_ofs[lg] + 1) % size;
			end
		end
		phase_cnt[lg] = ph & SAT;
		r.owned = 1'b1;
		r.lgroup = lg[5:0];
		r.slot = slot[8:0];
		r.wear = w[31:0];
		r.total = fail_cnt[31:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			nxt_start = start;
			if (start && !busy) begin
				expected_q.push_back(map_write(logical_line));
				nxt_start = 1'b0;
				hold = pick_gap();
			end
			if (!nxt_start) begin
				if (hold > 0)
					hold--;
				else if (line_q.size() > 0) begin
					logical_line <= line_q.pop_front();
					nxt_start = 1'b1;
				end
			end
			start <= nxt_start;
		end
	end

	task automatic report(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_q.size() == 0)
				report("unexpected result", 1, 0);
			else begin
				wear_result_t e;
				e = expected_q.pop_front();
				n_results++;
				n_owned += e.owned;
				n_failed += e.failed;
				n_moved += e.moved;
				if (owned !== e.owned) report("owned", owned, e.owned);
				if (local_group !== e.lgroup) report("local_group", local_group, e.lgroup);
				if (physical_slot !== e.slot) report("physical_slot", physical_slot, e.slot);
				if (slot_wear !== e.wear) report("slot_wear", slot_wear, e.wear);
				if (slot_failed !== e.failed) report("slot_failed", slot_failed, e.failed);
				if (gap_moved !== e.moved) report("gap_moved", gap_moved, e.moved);
				if (failure_total !== e.total)
					report("failure_total", failure_total, e.total);
			end
		end
	end

	task automatic wait_idle();
		do @(posedge clk);
		while (line_q.size() != 0 || expected_q.size() != 0 || start || hold != 0);
	endtask

	task automatic write_reg(input logic [sgwl_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] val);
		logic [31:0] d;
		d = val;
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			sgwl_pkg::REG_NODE_COUNT:  node_cnt = d[14:0];
			sgwl_pkg::REG_GROUP_COUNT: grp_cnt = d[6:0];
			sgwl_pkg::REG_SPLIT_POINT: split_pt = d[13:0];
			sgwl_pkg::REG_GAP_PERIOD:  period = d;
			sgwl_pkg::REG_WEAR_LIMIT:  limit = d;
			sgwl_pkg::REG_UNIT_COUNT:  units = d[6:0];
			sgwl_pkg::REG_UNIT_INDEX:  unit_no = d[5:0];
			default: ;
		endcase
	endtask

	// upper bits random so the whole data bus toggles
	function automatic logic [31:0] junk(input logic [31:0] v, input int w);
		logic [31:0] m;
		m = (32'h1 << w) - 1;
		return ($urandom() & ~m) | (v & m);
	endfunction

	task automatic push_lines(input int n, input int lo, input int hi);
		for (int i = 0; i < n; i++)
			line_q.push_back(($urandom_range(0, 4) == 0) ? $urandom_range(0, 16383)
				: $urandom_range(lo, hi));
	endtask

	task automatic set_all(input int nc, input int gc, input int sp, input logic [31:0] gp,
			input logic [31:0] wl, input int uc, input int ui);
		write_reg(sgwl_pkg::REG_NODE_COUNT, junk(nc, 15));
		write_reg(sgwl_pkg::REG_GROUP_COUNT, junk(gc, 7));
		write_reg(sgwl_pkg::REG_SPLIT_POINT, junk(sp, 14));
		write_reg(sgwl_pkg::REG_GAP_PERIOD, gp);
		write_reg(sgwl_pkg::REG_WEAR_LIMIT, wl);
		write_reg(sgwl_pkg::REG_UNIT_COUNT, junk(uc, 7));
		write_reg(sgwl_pkg::REG_UNIT_INDEX, junk(ui, 6));
	endtask

	initial begin
		node_cnt = sgwl_pkg::RST_NODE_COUNT;
		grp_cnt = sgwl_pkg::RST_GROUP_COUNT;
		split_pt = sgwl_pkg::RST_SPLIT_POINT;
		period = sgwl_pkg::RST_GAP_PERIOD;
		limit = sgwl_pkg::RST_WEAR_LIMIT;
		units = sgwl_pkg::RST_UNIT_COUNT;
		unit_no = sgwl_pkg::RST_UNIT_INDEX;
		foreach (wear_mem[i]) wear_mem[i] = 0;
		foreach (start_ofs[i]) begin
			start_ofs[i] = 0; gap_cnt[i] = 0; phase_cnt[i] = 0;
		end
		fail_cnt = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: range ends, split boundary, lines past node_count
		foreach (corner_lines[i])
			line_q.push_back(corner_lines[i]);
		push_lines(110, 0, 600);
		wait_idle();

		// small groups, upper unit, fast gap and quick wear-out
		set_all(40, 8, 17, 1, 3, 2, 1);
		no_idle = 1;
		push_lines(60, 0, 47);
		wait_idle();
		no_idle = 0;
		push_lines(240, 0, 47);
		wait_idle();

		// largest groups, last unit, zero period, every write fails
		set_all(16384, 64, 16383, 0, 1, 64, 63);
		push_lines(100, 16191, 16383);
		wait_idle();

		// maximum period and limit, then period lowered below the running phase
		set_all(30, 5, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0);
		push_lines(70, 0, 35);
		wait_idle();
		write_reg(sgwl_pkg::REG_GAP_PERIOD, 2);
		push_lines(80, 0, 35);
		wait_idle();

		// uneven sizes, zero wear limit
		set_all(100, 7, 29, 3, 0, 3, 0);
		push_lines(150, 0, 120);
		wait_idle();

		// degenerate settings: nothing owned
		write_reg(REG_UNUSED, $urandom());
		write_reg(sgwl_pkg::REG_GROUP_COUNT, 0);
		push_lines(5, 0, 16383);
		wait_idle();
		set_all(3, 7, 2, 5, 10, 0, 0);
		push_lines(5, 0, 16383);
		wait_idle();
		write_reg(sgwl_pkg::REG_UNIT_COUNT, 1);
		push_lines(5, 0, 16383);
		wait_idle();
		set_all(16384, 127, 16383, 5, 10, 1, 0);
		push_lines(5, 0, 16383);
		wait_idle();
		write_reg(sgwl_pkg::REG_GROUP_COUNT, 63);
		push_lines(5, 0, 16383);
		wait_idle();

		repeat (80) @(posedge clk);
		$display("covered %0d writes over 11 register settings: %0d owned, %0d slot failures,",
			n_results, n_owned, n_failed);
		$display("%0d gap moves, %0d mismatches", n_moved, errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#(800000 * 8);
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/sgwl_pkg.sv
sv/sgwl_div.sv
sv/start_gap_wear_leveler.sv
sv/sgwl_checker.sv
sim/tb_top.sv
